### rtl/core/selective_repeat_sender_window_assert.svh
// Assertion macros shared by the sender window RTL.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_ASSERT_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define SRSW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("srsw: property violated");
// cond must never be true outside reset
`define SRSW_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("srsw: forbidden condition");
`else
`define SRSW_ASSERT(lbl, prop)
`define SRSW_NEVER(lbl, cond)
`endif
`endif

### rtl/core/srsw_pkg.sv
// Types and constants of the selective-repeat sender window.
package srsw_pkg;

  localparam int SEQ_W   = 16;
  localparam int SLOT_W  = 4;
  localparam int KIND_W  = 3;
  localparam int MODE_W  = 2;
  localparam int LIMIT_W = 5;
  localparam int INFL_W  = 5;
  localparam int HARD_CAP = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

  typedef enum logic [MODE_W-1:0] {
    MODE_SUBMIT  = 2'd0,
    MODE_ACK     = 2'd1,
    MODE_TIMEOUT = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NEW     = 3'd0,
    KIND_RESEND  = 3'd1,
    KIND_REFUSED = 3'd2,
    KIND_TAKEN   = 3'd3,
    KIND_IGNORED = 3'd4,
    KIND_NONE    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLIDE,
    ST_WALK,
    ST_END
  } state_e;

endpackage

### rtl/core/selective_repeat_sender_window.sv
// Selective-repeat sender window: submit / ack / timeout sequencer over an ack-flag RAM.
// Submit, ignored ack, empty timeout: result in the cycle after start, busy stays low.
// Taken ack: busy while the base slides past acked frames (one per RAM read), then the TAKEN result.
// Timeout with pending base: busy while each in-flight slot is walked, one slot read per cycle.
// Async active-low reset empties the window (base = next = 0) and sets window_limit to 10;
// the flag RAM is not swept, since an entry is only read after a submit has written it.
`include "selective_repeat_sender_window_assert.svh"

module selective_repeat_sender_window #(
  parameter int WINDOW_SLOTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [srsw_pkg::MODE_W-1:0]   mode_i,
  input  logic [srsw_pkg::SEQ_W-1:0]    ack_seq_i,
  // result channel, one word per strobe
  output logic                          res_valid_o,
  output logic [srsw_pkg::KIND_W-1:0]   kind_o,
  output logic [srsw_pkg::SEQ_W-1:0]    seq_o,
  output logic [srsw_pkg::SLOT_W-1:0]   slot_o,
  output logic                          last_o,
  output logic [srsw_pkg::SEQ_W-1:0]    window_base_o,
  output logic [srsw_pkg::INFL_W-1:0]   in_flight_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import srsw_pkg::*;

  localparam int AW  = $clog2(WINDOW_SLOTS);
  localparam int CAP = (WINDOW_SLOTS < HARD_CAP) ? WINDOW_SLOTS : HARD_CAP;
  localparam logic [LIMIT_W-1:0] LIM_CAP   = LIMIT_W'(CAP);
  // slot field is seq mod slot count, masked to the 4-bit port
  localparam logic [SLOT_W-1:0]  SLOT_MASK = SLOT_W'(WINDOW_SLOTS - 1);

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [LIMIT_W-1:0]  limit_q;
  logic [SEQ_W-1:0]    base_q, base_d;
  logic [SEQ_W-1:0]    next_q, next_d;
  logic [SEQ_W-1:0]    ack_q, ack_d;       // ack being processed
  logic [INFL_W-1:0]   walk_q, walk_d;     // window offset whose flag is on rd_data
  logic [SEQ_W-1:0]    pend_q, pend_d;     // resend held back until the next one is known
  logic                pend_vld_q, pend_vld_d;

  logic                res_vld_q;
  logic [KIND_W-1:0]   kind_q;
  logic [SEQ_W-1:0]    seq_q;
  logic [SLOT_W-1:0]   slot_q;
  logic                last_q;
  logic [SEQ_W-1:0]    wbase_q;
  logic [INFL_W-1:0]   infl_q;

  // ------------------------------------------------------------------
  // Shared decode
  // ------------------------------------------------------------------
  logic               accept;
  logic [SEQ_W-1:0]   flight;
  logic [SEQ_W-1:0]   ack_off;
  logic [LIMIT_W-1:0] lim;
  logic               win_full;
  logic               ack_in_win;
  logic               base_flag;
  logic               walk_done;
  logic               rd_data;
  logic [SEQ_W-1:0]   walk_seq;
  logic [SEQ_W-1:0]   walk_seq_nxt;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign flight   = next_q - base_q;
  assign ack_off  = ack_seq_i - base_q;
  assign lim      = (limit_q > LIM_CAP) ? LIM_CAP : limit_q;
  assign win_full = (flight >= {{(SEQ_W-LIMIT_W){1'b0}}, lim});
  assign ack_in_win = (ack_off < flight);
  // the just-written ack flag is forwarded, the RAM read may predate it
  assign base_flag = rd_data || (base_q[AW-1:0] == ack_q[AW-1:0]);
  assign walk_seq     = base_q + SEQ_W'(walk_q);
  assign walk_seq_nxt = walk_seq + 16'd1;
  assign walk_done    = ((walk_q + 5'd1) == flight[INFL_W-1:0]);

  // ------------------------------------------------------------------
  // Ack flag RAM
  // ------------------------------------------------------------------
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ram_raddr;

  srsw_ram #(
    .WIDTH (1),
    .DEPTH (WINDOW_SLOTS)
  ) u_flags (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  // ------------------------------------------------------------------
  // Next state
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_ACK && ack_in_win) begin
            state_d = ST_SLIDE;
          end else if (mode_i == MODE_TIMEOUT && flight != '0) begin
            state_d = ST_WALK;
          end
        end
      end
      ST_SLIDE: begin
        if (!(flight != '0 && base_flag)) begin
          state_d = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (walk_q == '0 && rd_data) begin
          state_d = ST_IDLE;  // base already acked: nothing to resend
        end else if (walk_done) begin
          state_d = ST_END;
        end
      end
      ST_END: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Datapath and result selection
  // ------------------------------------------------------------------
  logic              emit;
  logic [KIND_W-1:0] emit_kind;
  logic [SEQ_W-1:0]  emit_seq;
  logic              emit_last;

  always_comb begin
    base_d     = base_q;
    next_d     = next_q;
    ack_d      = ack_q;
    walk_d     = walk_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    emit       = 1'b0;
    emit_kind  = KIND_NONE;
    emit_seq   = base_q;
    emit_last  = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = next_q[AW-1:0];
    ram_wdata  = 1'b0;
    ram_raddr  = base_q[AW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_SUBMIT: begin
              emit     = 1'b1;
              emit_seq = next_q;
              if (win_full) begin
                emit_kind = KIND_REFUSED;
              end else begin
                emit_kind = KIND_NEW;
                ram_we    = 1'b1;
                ram_waddr = next_q[AW-1:0];
                ram_wdata = 1'b0;
                next_d    = next_q + 16'd1;
              end
            end
            MODE_ACK: begin
              ack_d = ack_seq_i;
              if (ack_in_win) begin
                ram_we    = 1'b1;
                ram_waddr = ack_seq_i[AW-1:0];
                ram_wdata = 1'b1;
              end else begin
                emit      = 1'b1;
                emit_kind = KIND_IGNORED;
                emit_seq  = ack_seq_i;
              end
            end
            MODE_TIMEOUT: begin
              walk_d     = '0;
              pend_vld_d = 1'b0;
              if (flight == '0) begin
                emit      = 1'b1;
                emit_kind = KIND_NONE;
                emit_seq  = base_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SLIDE: begin
        if (flight != '0 && base_flag) begin
          base_d    = base_q + 16'd1;
          ram_raddr = base_d[AW-1:0];
        end else begin
          emit      = 1'b1;
          emit_kind = KIND_TAKEN;
          emit_seq  = ack_q;
        end
      end
      ST_WALK: begin
        if (walk_q == '0 && rd_data) begin
          emit      = 1'b1;
          emit_kind = KIND_NONE;
          emit_seq  = base_q;
        end else begin
          if (!rd_data) begin
            // flush the previous resend, hold this one until the next one is found or the walk ends
            if (pend_vld_q) begin
              emit      = 1'b1;
              emit_kind = KIND_RESEND;
              emit_seq  = pend_q;
              emit_last = 1'b0;
            end
            pend_d     = walk_seq;
            pend_vld_d = 1'b1;
          end
          walk_d    = walk_q + 5'd1;
          ram_raddr = walk_seq_nxt[AW-1:0];
        end
      end
      ST_END: begin
        emit      = 1'b1;
        emit_kind = KIND_RESEND;
        emit_seq  = pend_q;
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Sequential
  // ------------------------------------------------------------------
  logic [SEQ_W-1:0] flight_d;
  assign flight_d = next_d - base_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      limit_q    <= LIMIT_RESET;
      base_q     <= '0;
      next_q     <= '0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      base_q     <= base_d;
      next_q     <= next_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= emit;
      if (psel && penable && pwrite && !paddr[2]) begin
        limit_q <= pwdata[LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ack_q  <= ack_d;
    walk_q <= walk_d;
    pend_q <= pend_d;
    if (emit) begin
      kind_q  <= emit_kind;
      seq_q   <= emit_seq;
      slot_q  <= emit_seq[SLOT_W-1:0] & SLOT_MASK;
      last_q  <= emit_last;
      wbase_q <= base_d;
      infl_q  <= flight_d[INFL_W-1:0];
    end
  end

  // ------------------------------------------------------------------
  // Outputs
  // ------------------------------------------------------------------
  assign res_valid_o   = res_vld_q;
  assign kind_o        = kind_q;
  assign seq_o         = seq_q;
  assign slot_o        = slot_q;
  assign last_o        = last_q;
  assign window_base_o = wbase_q;
  assign in_flight_o   = infl_q;

  assign prdata = {{(32-LIMIT_W){1'b0}}, limit_q};
  assign pready = 1'b1;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `SRSW_ASSERT(a_window_bound, flight <= SEQ_W'(WINDOW_SLOTS))
  `SRSW_ASSERT(a_last_ends_item, res_vld_q && last_q |-> state_q == ST_IDLE)
  `SRSW_ASSERT(a_walk_in_window, state_q == ST_WALK |-> SEQ_W'(walk_q) < flight)
  `SRSW_NEVER(a_unused_mode_silent, $past(accept) && $past(mode_i) == MODE_UNUSED && res_vld_q)

endmodule

### rtl/core/srsw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module srsw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
